// ===== rtl/core/ntl_pkg.sv =====
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared constants, codes and types of the nearest timestamp lookup block.
// ----------------------------------------------------------------------------
package ntl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 48;
    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]  ts;
        logic [VALUE_W-1:0] value;
    } sample_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        sample_t          wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   index;
        logic [CNT_W-1:0]   count;
    } result_t;

endpackage

// ===== rtl/core/ntl_if.sv =====
// ----------------------------------------------------------------------------
// ntl_if
// Request and response channels of the nearest timestamp lookup block.
// ----------------------------------------------------------------------------
interface ntl_req_if
    import ntl_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [TIME_W-1:0]         entry_time;
    logic signed [VALUE_W-1:0] entry_value;
    logic [TIME_W-1:0]         query_time;

    modport source (output valid, req_type, entry_time, entry_value, query_time,
                    input ready);
    modport sink   (input valid, req_type, entry_time, entry_value, query_time,
                    output ready);
endinterface

interface ntl_rsp_if
    import ntl_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] result_value;
    logic [IDX_W-1:0]          nearest_index;
    logic [CNT_W-1:0]          entry_count;

    modport source (output valid, status, result_value, nearest_index, entry_count,
                    input ready);
    modport sink   (input valid, status, result_value, nearest_index, entry_count,
                    output ready);
endinterface

// ===== rtl/core/nearest_timestamp_lookup.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_lookup
// Table of timestamped samples with nearest-in-time lookup by binary search.
// ----------------------------------------------------------------------------
// Samples (48-bit microsecond timestamp, 32-bit Q16.16 value) are appended
// into a 1024-entry memory; the user must append them in ascending time order,
// the block itself does not enforce it. A query returns the value and index of
// the sample nearest the queried time: at or before the first sample gives the
// first, at or after the last gives the last, otherwise a binary search finds
// the first sample at or after the position and a tie in distance picks the
// earlier one. Every request gives exactly one response item with a status
// (ok, query on empty table, append dropped because full) and the sample count
// after the request; clear empties the table. One item is handled at a time.
// An append, clear or unused request passes through the sequencer's result
// register and then the output register. A query is paced by the single read
// port of the sample memory: one read per search step plus the two end checks
// and the read of the lower neighbor. The next item is taken as soon as the
// sequencer is idle again, even while the previous response waits on the
// output register. Memory contents are not cleared; only the count resets.
// ----------------------------------------------------------------------------
module nearest_timestamp_lookup
    import ntl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ntl_req_if.sink   req,
    ntl_rsp_if.source rsp
);

    mem_req_t mem_req;
    sample_t  rd_data;
    result_t  res;
    logic     res_valid;
    logic     res_ready;

    logic     rsp_valid_reg;
    result_t  rsp_data_reg;

    ntl_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    ntl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // output register: frees the sequencer while a response waits downstream
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_data_reg.status;
    assign rsp.result_value  = rsp_data_reg.value;
    assign rsp.nearest_index = rsp_data_reg.index;
    assign rsp.entry_count   = rsp_data_reg.count;

endmodule

// ===== rtl/core/ntl_store.sv =====
// ----------------------------------------------------------------------------
// ntl_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ntl_store
    import ntl_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output sample_t  rd_data
);

    sample_t sample_mem [TABLE_DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            sample_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= sample_mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ntl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntl_ctrl
// Request sequencer: appends, clears, end checks, binary search, tie compare.
// ----------------------------------------------------------------------------
module ntl_ctrl
    import ntl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ntl_req_if.sink   req,
    output mem_req_t  mem_req,
    input  sample_t   rd_data,
    output result_t   res,
    output logic      res_valid,
    input  logic      res_ready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FIRST  = 6'b000010,
        S_LAST   = 6'b000100,
        S_SEARCH = 6'b001000,
        S_BELOW  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    sample_t           hi_smp_reg, hi_smp_next;
    result_t           res_reg, res_next;

    logic                     accept;
    logic [IDX_W-1:0]         lo_c, hi_c;
    logic [IDX_W:0]           sum_c;
    logic signed [TIME_W:0]   below_c, above_c;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign res       = res_reg;
    assign res_valid = (state_reg == S_RESP);

    // distances as in a signed 64-bit subtract; 49 bits hold every difference
    assign below_c = $signed({1'b0, pos_reg}) - $signed({1'b0, rd_data.ts});
    assign above_c = $signed({1'b0, hi_smp_reg.ts}) - $signed({1'b0, pos_reg});

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        hi_smp_next = hi_smp_reg;
        res_next    = res_reg;
        mem_req     = '0;
        lo_c        = lo_reg;
        hi_c        = hi_reg;
        sum_c       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{status: STAT_OK, value: '0, index: '0, count: count_reg};
                    state_next = S_RESP;
                    case (req.req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en         = 1'b1;
                                mem_req.wr_addr       = count_reg[IDX_W-1:0];
                                mem_req.wr_data.ts    = req.entry_time;
                                mem_req.wr_data.value = req.entry_value;
                                count_next            = count_reg + 1'b1;
                                res_next.count        = count_reg + 1'b1;
                            end
                        end
                        REQ_QUERY:
                        begin
                            pos_next = req.query_time;
                            if (count_reg == '0)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                last_next       = IDX_W'(count_reg - 1'b1);
                                state_next      = S_FIRST;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next     = '0;
                            res_next.count = '0;
                        end
                        default:
                        begin
                            // unused code: no change, plain ok result
                        end
                    endcase
                end
            end

            S_FIRST:
            begin
                if (pos_reg <= rd_data.ts)
                begin
                    res_next   = '{status: STAT_OK, value: rd_data.value, index: '0,
                                   count: count_reg};
                    state_next = S_RESP;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = last_reg;
                    state_next      = S_LAST;
                end
            end

            S_LAST:
            begin
                if (pos_reg >= rd_data.ts)
                begin
                    res_next   = '{status: STAT_OK, value: rd_data.value, index: last_reg,
                                   count: count_reg};
                    state_next = S_RESP;
                end
                else
                begin
                    // here first < pos < last, so the table holds at least two
                    lo_next         = '0;
                    hi_next         = last_reg;
                    hi_smp_next     = rd_data;
                    sum_c           = {1'b0, last_reg};
                    mid_next        = sum_c[IDX_W:1];
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = sum_c[IDX_W:1];
                    state_next      = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (rd_data.ts < pos_reg)
                begin
                    lo_c = mid_reg + 1'b1;
                end
                else
                begin
                    hi_c        = mid_reg;
                    hi_smp_next = rd_data;
                end
                lo_next       = lo_c;
                hi_next       = hi_c;
                sum_c         = {1'b0, lo_c} + {1'b0, hi_c};
                mem_req.rd_en = 1'b1;
                if (lo_c < hi_c)
                begin
                    mid_next        = sum_c[IDX_W:1];
                    mem_req.rd_addr = sum_c[IDX_W:1];
                end
                else
                begin
                    // lo is at least one since the first sample lies below pos
                    mem_req.rd_addr = lo_c - 1'b1;
                    state_next      = S_BELOW;
                end
            end

            S_BELOW:
            begin
                // tie goes to the earlier sample
                if (below_c <= above_c)
                begin
                    res_next = '{status: STAT_OK, value: rd_data.value,
                                 index: lo_reg - 1'b1, count: count_reg};
                end
                else
                begin
                    res_next = '{status: STAT_OK, value: hi_smp_reg.value,
                                 index: lo_reg, count: count_reg};
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        hi_smp_reg <= hi_smp_next;
        res_reg    <= res_next;
    end

endmodule

// ===== rtl/core/ntl_checker.sv =====
// ----------------------------------------------------------------------------
// ntl_checker
// Port-level checks on the nearest timestamp lookup responses.
// ----------------------------------------------------------------------------
module ntl_checker
    import ntl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [STAT_W-1:0]  status,
    input logic [VALUE_W-1:0] result_value,
    input logic [IDX_W-1:0]   nearest_index,
    input logic [CNT_W-1:0]   entry_count
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(result_value) && $stable(nearest_index) && $stable(entry_count))
        else $error("response changed while stalled");

    // dropped append only with a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_FULL |-> entry_count == CNT_W'(TABLE_DEPTH))
        else $error("full status with table not full");

    // empty query gives zero everywhere
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_EMPTY |->
            entry_count == '0 && result_value == '0 && nearest_index == '0)
        else $error("empty status with nonzero fields");

    // chosen index lies inside the table
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, nearest_index} < entry_count)
            || (entry_count == '0 && nearest_index == '0))
        else $error("index outside stored samples");

endmodule

bind nearest_timestamp_lookup ntl_checker u_ntl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .result_value  (rsp.result_value),
    .nearest_index (rsp.nearest_index),
    .entry_count   (rsp.entry_count)
);
